### sv/rth_pkg.sv
// Package for the RGB to HSV/HSL converter: request/result structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package rth_pkg;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_req;

    typedef struct packed {
        logic [15:0] hue_centideg;
        logic [7:0]  sat_hsv;
        logic [7:0]  value_hsv;
        logic [7:0]  sat_hsl;
        logic [7:0]  lightness;
        logic [7:0]  alpha_out;
    } t_res;

    // three divisions carried through the cell row
    typedef struct packed {
        logic [26:0] rem_h;   // remainder, hue
        logic [26:0] num_h;   // shifting numerator bits / quotient
        logic [9:0]  den_h;
        logic [26:0] rem_v;
        logic [26:0] num_v;
        logic [9:0]  den_v;
        logic [26:0] rem_l;
        logic [26:0] num_l;
        logic [9:0]  den_l;
        logic        grey;
        logic [7:0]  mx;
        logic [7:0]  light;
        logic [7:0]  alpha;
    } t_cell;

    localparam int QW = 27;          // numerator width: 2*36000*255 < 2^25, margin
    localparam logic [15:0] HUE_GREY = 16'hFFFF;
endpackage

### sv/rgb_to_hsv_hsl.sv
// Top level of the RGB to HSV/HSL converter: front stage, cell row, output register.
// Depends on rth_pkg and rth_cell.
`timescale 1ns / 1ps
// Usage:
//   Drive i_req and pulse i_start; busy is tied low, so a request is taken
//   every cycle. Each request yields one result on o_res, flagged by o_done
//   for exactly one cycle; the receiver cannot stall, none is needed.
//   Pipeline: a front stage (max/min, numerators), QW = 27 division cells
//   (one quotient bit each, three dividers in parallel), then 1 output
//   register. Throughput: one pixel per cycle, set by the cell
//   row, which is fully pipelined.
//   Each ratio round(n/d) is computed as floor((2n+d)/(2d)).
//   Grey pixels run the row with dummy divisors of 1 and are overridden at
//   the output (hue 65535, both saturations 0).
//   Reset (synchronous, active low) clears all valid flags; data in flight
//   is dropped.
module rgb_to_hsv_hsl
    import rth_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_res o_res
);
    assign o_busy = 1'b0;

    // front: max, min, numerators
    logic [7:0] mx, mn, dl;
    logic [8:0] sm;
    logic signed [24:0] hn;
    logic [9:0] dh, dv, dsl;
    logic [25:0] nh;
    logic [18:0] ns;
    t_cell f;

    always_comb begin
        logic [7:0] r, g, b;
        r = i_req.red; g = i_req.green; b = i_req.blue;
        mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
        mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
        dl = mx - mn;
        sm = {1'b0, mx} + {1'b0, mn};
        if (r == mx)      hn = 25'sd6000 * ($signed({17'd0, g}) - $signed({17'd0, b}));
        else if (g == mx) hn = 25'sd12000 * $signed({17'd0, dl})
                              + 25'sd6000 * ($signed({17'd0, b}) - $signed({17'd0, r}));
        else              hn = 25'sd24000 * $signed({17'd0, dl})
                              + 25'sd6000 * ($signed({17'd0, r}) - $signed({17'd0, g}));
        // a negative hue numerator is wrapped by adding 36000*dl; it fits 24 bits, built as 26
        nh = (hn < 0) ? 26'(26'($signed(hn)) + 26'd36000 * {18'd0, dl})
                      : 26'($unsigned(hn));
        ns = 19'd255 * {11'd0, dl};
        if (dl == 8'd0) begin
            dh = 10'd1; dv = 10'd1; dsl = 10'd1;
        end else begin
            dh = {2'd0, dl};
            dv = {2'd0, mx};
            dsl = (sm < 9'd255) ? {1'b0, sm} : 10'(10'd510 - {1'b0, sm});
        end
        f = '0;
        f.den_h = 10'(dh << 1);
        f.den_v = 10'(dv << 1);
        f.den_l = 10'(dsl << 1);
        f.num_h = 27'({nh, 1'b0} + {17'd0, dh});
        f.num_v = 27'({8'd0, ns, 1'b0} + {17'd0, dv});
        f.num_l = 27'({8'd0, ns, 1'b0} + {17'd0, dsl});
        f.grey  = (dl == 8'd0);
        f.mx    = mx;
        f.light = 8'(({1'b0, sm} + 10'd1) >> 1);
        f.alpha = i_req.alpha;
    end

    t_cell r_f;
    logic  r_fv;
    always_ff @(posedge i_clk) begin
        r_f <= f;
        if (!i_rst_n) r_fv <= 1'b0;
        else          r_fv <= i_start;
    end

    // cell row; denominators were doubled so the quotient is the rounded ratio
    t_cell w_d [QW+1];
    logic  w_v [QW+1];
    assign w_d[0] = r_f;
    assign w_v[0] = r_fv;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        rth_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(w_v[k]), .i_d(w_d[k]),
            .o_vld(w_v[k+1]), .o_d(w_d[k+1])
        );
    end

    t_cell l;
    t_res r_res;
    logic r_done;
    assign l = w_d[QW];
    always_ff @(posedge i_clk) begin
        r_res.hue_centideg <= l.grey ? HUE_GREY : l.num_h[15:0];
        r_res.sat_hsv      <= l.grey ? 8'd0 : l.num_v[7:0];
        r_res.value_hsv    <= l.mx;
        r_res.sat_hsl      <= l.grey ? 8'd0 : l.num_l[7:0];
        r_res.lightness    <= l.light;
        r_res.alpha_out    <= l.alpha;
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= w_v[QW];
    end
    assign o_done = r_done;
    assign o_res  = r_res;

    // a request entering the cell row appears as a result on o_done, after the cells and the output register
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[0] |-> ##(QW+1) o_done) else $error("result lost in cell row");
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.hue_centideg == HUE_GREY) |-> (o_res.sat_hsv == 8'd0))
        else $error("grey pixel with saturation");
    a_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.hue_centideg < 16'd36000 || o_res.hue_centideg == HUE_GREY))
        else $error("hue out of range");
endmodule

### sv/rth_cell.sv
// One restoring-division cell: one quotient bit for each of three dividers.
// Depends on rth_pkg.
`timescale 1ns / 1ps
module rth_cell
    import rth_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_cell  i_d,
    output logic   o_vld,
    output t_cell  o_d
);
    t_cell r_d, n_d;
    logic  r_vld;

    function automatic void step(input logic [26:0] rem, input logic [26:0] num,
                                 input logic [9:0] den,
                                 output logic [26:0] rem_o, output logic [26:0] num_o);
        logic [27:0] t;
        logic [27:0] dd;
        t  = {rem, num[26]};
        dd = {18'd0, den};
        if (t >= dd) begin
            rem_o = 27'(t - dd);
            num_o = {num[25:0], 1'b1};
        end else begin
            rem_o = t[26:0];
            num_o = {num[25:0], 1'b0};
        end
    endfunction

    always_comb begin
        n_d = i_d;
        step(i_d.rem_h, i_d.num_h, i_d.den_h, n_d.rem_h, n_d.num_h);
        step(i_d.rem_v, i_d.num_v, i_d.den_v, n_d.rem_v, n_d.num_v);
        step(i_d.rem_l, i_d.num_l, i_d.den_l, n_d.rem_l, n_d.num_l);
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;
endmodule
